// ===== rtl/core/bcd_date_time_zone_offset_macros.svh =====
// assertion macros for the bcd date/time zone offset block
// used by bcd_date_time_zone_offset.sv, which carries concurrent checks, needs clock and reset in scope
`ifndef BCD_DATE_TIME_ZONE_OFFSET_MACROS_SVH
`define BCD_DATE_TIME_ZONE_OFFSET_MACROS_SVH

// same-cycle implication
`define BDTZ_ASSERT_NOW(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error("bdtz check failed");

// next-cycle implication
`define BDTZ_ASSERT_NEXT(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error("bdtz check failed");

`endif

// ===== rtl/core/bdtz_pkg.sv =====
// shared types, constants and bcd helper functions for the zone offset block
// no dependencies
`default_nettype none

package bdtz_pkg;

   typedef struct packed {
      logic [7:0] year_bcd;
      logic [7:0] month_bcd;
      logic [7:0] day_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] second_bcd;
   } req_type;

   typedef struct packed {
      logic [7:0] local_year_bcd;
      logic [4:0] local_month_bcd;
      logic [5:0] local_day_bcd;
      logic [5:0] local_hour_bcd;
      logic [6:0] local_minute_bcd;
      logic [6:0] local_second_bcd;
      logic       bad_digit;
   } rsp_type;

   // decoded zone offset
   typedef struct packed {
      logic       neg;
      logic       half;
      logic [3:0] hours;
   } zone_type;

   localparam logic signed [7:0] OFFSET_LIMIT   = 8'sd120;
   localparam logic [6:0]        HOURS_PER_DAY  = 7'd24;
   localparam logic [6:0]        LAST_HOUR      = 7'd23;
   localparam logic [6:0]        LAST_MINUTE    = 7'd59;
   localparam logic [6:0]        HALF_HOUR      = 7'd30;
   localparam logic [6:0]        MAX_DAY        = 7'd31;
   localparam logic [6:0]        DEC_ROLL_DAY   = 7'd32;
   localparam logic [6:0]        YEAR_MAX       = 7'd99;
   localparam logic [4:0]        DAYS_LONG      = 5'd31;
   localparam logic [4:0]        DAYS_SHORT     = 5'd30;
   localparam logic [4:0]        DAYS_FEB_LEAP  = 5'd29;
   localparam logic [4:0]        DAYS_FEB       = 5'd28;
   localparam logic [3:0]        DIGIT_MAX      = 4'd9;

   localparam logic [6:0] MONTH_JAN = 7'd1;
   localparam logic [6:0] MONTH_FEB = 7'd2;
   localparam logic [6:0] MONTH_APR = 7'd4;
   localparam logic [6:0] MONTH_JUN = 7'd6;
   localparam logic [6:0] MONTH_SEP = 7'd9;
   localparam logic [6:0] MONTH_NOV = 7'd11;
   localparam logic [6:0] MONTH_DEC = 7'd12;

   // floor(v / 10) by reciprocal, exact for all 7-bit values
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      p = {8'd0, v} * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [6:0] bcd_to_bin(input logic [7:0] b);
      logic [6:0] hi;
      logic [6:0] lo;
      hi = {3'd0, b[7:4]};
      lo = {3'd0, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] ones;
      tens = div10(v);
      ones = v - ((({3'd0, tens}) << 3) + (({3'd0, tens}) << 1));
      return {tens, ones[3:0]};
   endfunction

   function automatic logic digit_bad(input logic [7:0] b);
      return (b[7:4] > DIGIT_MAX) || (b[3:0] > DIGIT_MAX);
   endfunction

   function automatic logic [4:0] month_len(input logic [6:0] mo, input logic leap);
      logic [4:0] len;
      priority if (mo == MONTH_APR || mo == MONTH_JUN || mo == MONTH_SEP ||
                   mo == MONTH_NOV) begin
         len = DAYS_SHORT;
      end else if (mo == MONTH_FEB) begin
         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      end else begin
         len = DAYS_LONG;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcd_date_time_zone_offset.sv =====
// Converts a packed-BCD UTC timestamp to local time using a zone offset register written
// through csr_wr_en / csr_wr_data (signed tenths of an hour, saturated to +-12.0 h). Each
// item passes an input register, one combinational conversion and a result register that
// drives rsp_valid, and one item is accepted every cycle while the result side keeps up;
// req_stall rises only when both registers are full and rsp_stall is high. Items with a
// BCD digit above 9 or a field out of calendar range pass through without the offset, cut
// to the output field widths; bad_digit marks the former. Write the offset only while idle.
`default_nettype none

`include "bcd_date_time_zone_offset_macros.svh"

module bcd_date_time_zone_offset (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bdtz_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bdtz_pkg::rsp_type     rsp_data
);
   import bdtz_pkg::*;

   zone_type zone;
   logic     s1_valid_ff;
   logic     s1_valid_in;
   req_type  s1_data_ff;
   req_type  s1_data_in;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;
   rsp_type  conv;
   logic     s2_open;
   logic     s1_move;

   bdtz_zone u_zone (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .zone        (zone)
   );

   bdtz_convert u_convert (
      .d    (s1_data_ff),
      .zone (zone),
      .r    (conv)
   );

   always_comb begin
      s2_open   = !rsp_valid_ff || !rsp_stall;
      s1_move   = s1_valid_ff && s2_open;
      req_stall = s1_valid_ff && !s2_open;

      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s2_open) begin
         rsp_valid_in = s1_valid_ff;
         rsp_data_in  = conv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // back-pressure only with a held item in the input register
   `BDTZ_ASSERT_NOW(a_stall_needs_item, req_stall, s1_valid_ff)
   // an item leaving the input register shows up as a result
   `BDTZ_ASSERT_NEXT(a_move_to_result, s1_move, rsp_valid_ff)
   // a blocked item waits in place
   `BDTZ_ASSERT_NEXT(a_blocked_item_holds, s1_valid_ff && !s2_open,
                     s1_valid_ff && $stable(s1_data_ff))

endmodule

`default_nettype wire

// ===== rtl/core/bdtz_zone.sv =====
// zone offset register with saturation and split into sign, half hour and hours
// depends on bdtz_pkg
`default_nettype none

module bdtz_zone (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   output bdtz_pkg::zone_type    zone
);
   import bdtz_pkg::*;

   logic signed [7:0] offset_ff;
   logic signed [7:0] offset_in;
   logic signed [7:0] sat;
   logic        [6:0] mag;
   logic        [3:0] whole;
   logic        [6:0] rem;

   always_comb begin
      offset_in = csr_wr_en ? $signed(csr_wr_data) : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      priority if (offset_ff > OFFSET_LIMIT) begin
         sat = OFFSET_LIMIT;
      end else if (offset_ff < -OFFSET_LIMIT) begin
         sat = -OFFSET_LIMIT;
      end else begin
         sat = offset_ff;
      end
      mag   = sat[7] ? 7'(-sat) : sat[6:0];
      whole = div10(mag);
      rem   = mag - ((({3'd0, whole}) << 3) + (({3'd0, whole}) << 1));
      zone.neg   = sat[7];
      zone.half  = (rem != 7'd0);
      zone.hours = whole;
   end

endmodule

`default_nettype wire

// ===== rtl/core/bdtz_convert.sv =====
// combinational utc to local conversion of one timestamp item
// depends on bdtz_pkg
`default_nettype none

module bdtz_convert (
   input  wire bdtz_pkg::req_type  d,
   input  wire bdtz_pkg::zone_type zone,
   output bdtz_pkg::rsp_type       r
);
   import bdtz_pkg::*;

   logic              bad;
   logic              in_range;
   logic        [6:0] yr;
   logic        [6:0] mo;
   logic        [6:0] dy;
   logic        [6:0] hr;
   logic        [6:0] mi;
   logic        [6:0] yr_o;
   logic        [6:0] mo_o;
   logic        [6:0] dy_o;
   logic        [6:0] mi_o;
   logic signed [6:0] hr_s;
   logic signed [6:0] hours_s;
   logic        [7:0] yr_b;
   logic        [7:0] mo_b;
   logic        [7:0] dy_b;
   logic        [7:0] hr_b;
   logic        [7:0] mi_b;

   always_comb begin
      bad = digit_bad(d.year_bcd) || digit_bad(d.month_bcd) || digit_bad(d.day_bcd) ||
            digit_bad(d.hour_bcd) || digit_bad(d.minute_bcd) || digit_bad(d.second_bcd);

      yr = bcd_to_bin(d.year_bcd);
      mo = bcd_to_bin(d.month_bcd);
      dy = bcd_to_bin(d.day_bcd);
      hr = bcd_to_bin(d.hour_bcd);
      mi = bcd_to_bin(d.minute_bcd);

      in_range = (mo >= MONTH_JAN) && (mo <= MONTH_DEC) && (dy >= 7'd1) && (dy <= MAX_DAY) &&
                 (hr <= LAST_HOUR) && (mi <= LAST_MINUTE);

      // half hour step on the minutes
      hr_s = $signed(hr);
      mi_o = mi;
      if (zone.half) begin
         if (!zone.neg) begin
            if (mi >= HALF_HOUR) begin
               mi_o = mi - HALF_HOUR;
               hr_s = hr_s + 7'sd1;
            end else begin
               mi_o = mi + HALF_HOUR;
            end
         end else begin
            if (mi < HALF_HOUR) begin
               mi_o = mi + HALF_HOUR;
               hr_s = hr_s - 7'sd1;
            end else begin
               mi_o = mi - HALF_HOUR;
            end
         end
      end

      hours_s = $signed({3'd0, zone.hours});
      hr_s    = zone.neg ? hr_s - hours_s : hr_s + hours_s;

      yr_o = yr;
      mo_o = mo;
      dy_o = dy;
      priority if (hr_s < 7'sd0) begin
         // borrow a day
         hr_s = hr_s + $signed(HOURS_PER_DAY);
         if (dy == 7'd1) begin
            if (mo == MONTH_JAN) begin
               mo_o = MONTH_DEC;
               yr_o = (yr == 7'd0) ? YEAR_MAX : yr - 7'd1;
            end else begin
               mo_o = mo - 7'd1;
            end
            dy_o = {2'd0, month_len(mo_o, yr_o[1:0] == 2'd0)};
         end else begin
            dy_o = dy - 7'd1;
         end
      end else if (hr_s > $signed(LAST_HOUR)) begin
         // carry a day, december rolls over only at day 32
         hr_s = hr_s - $signed(HOURS_PER_DAY);
         dy_o = dy + 7'd1;
         if (mo == MONTH_DEC) begin
            if (dy_o == DEC_ROLL_DAY) begin
               dy_o = 7'd1;
               mo_o = MONTH_JAN;
               yr_o = (yr == YEAR_MAX) ? 7'd0 : yr + 7'd1;
            end
         end else if (dy_o == {2'd0, month_len(mo, yr[1:0] == 2'd0)} + 7'd1) begin
            dy_o = 7'd1;
            mo_o = mo + 7'd1;
         end
      end else begin
         hr_s = hr_s;
      end

      yr_b = bin_to_bcd(yr_o);
      mo_b = bin_to_bcd(mo_o);
      dy_b = bin_to_bcd(dy_o);
      hr_b = bin_to_bcd(hr_s[6:0]);
      mi_b = bin_to_bcd(mi_o);

      if (bad || !in_range) begin
         r.local_year_bcd   = d.year_bcd;
         r.local_month_bcd  = d.month_bcd[4:0];
         r.local_day_bcd    = d.day_bcd[5:0];
         r.local_hour_bcd   = d.hour_bcd[5:0];
         r.local_minute_bcd = d.minute_bcd[6:0];
      end else begin
         r.local_year_bcd   = yr_b;
         r.local_month_bcd  = mo_b[4:0];
         r.local_day_bcd    = dy_b[5:0];
         r.local_hour_bcd   = hr_b[5:0];
         r.local_minute_bcd = mi_b[6:0];
      end
      r.local_second_bcd = d.second_bcd[6:0];
      r.bad_digit        = bad;
   end

endmodule

`default_nettype wire

// ===== tb/sv/bcd_date_time_zone_offset_test.sv =====
// testbench for bcd_date_time_zone_offset: directed table then random timestamps,
// results checked in order against typed rows or a behavioral local-time predictor
// depends on bdtz_pkg and the bcd_date_time_zone_offset rtl
`timescale 1ns / 1ps

module bcd_date_time_zone_offset_test;
   import bdtz_pkg::*;

   localparam int ZONE_LIMIT      = 120;
   localparam int JANUARY         = 1;
   localparam int DECEMBER        = 12;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int LONG_HOLD       = 200;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DIRECTED_COUNT  = 22;

   typedef struct {
      logic [7:0] zone;
      req_type    stamp;
      bit         typed;
      rsp_type    local_time;
   } case_row_type;

   localparam rsp_type UNTYPED = '0;

   // stamp fields: year, month, day, hour, minute, second
   case_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'h00, {8'h24, 8'h02, 8'h29, 8'h12, 8'h34, 8'h56}, 1'b1,
        {8'h24, 5'h02, 6'h29, 6'h12, 7'h34, 7'h56, 1'b0}},
      '{8'h00, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
        {8'hFF, 5'h1F, 6'h3F, 6'h3F, 7'h7F, 7'h7F, 1'b1}},
      '{8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h00, 5'h00, 6'h00, 6'h00, 7'h00, 7'h00, 1'b0}},
      '{8'h00, {8'h9A, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h9A, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00, 1'b1}},
      '{8'h78, {8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 1'b1,
        {8'h00, 5'h01, 6'h01, 6'h11, 7'h59, 7'h59, 1'b0}},
      '{8'h78, {8'h24, 8'h04, 8'h30, 8'h12, 8'h00, 8'h00}, 1'b0, UNTYPED},
      '{8'h78, {8'h24, 8'h04, 8'h31, 8'h12, 8'h00, 8'h00}, 1'b0, UNTYPED},
      '{8'h78, {8'h24, 8'h12, 8'h30, 8'h18, 8'h00, 8'h00}, 1'b0, UNTYPED},
      '{8'h78, {8'h24, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h24, 5'h13, 6'h01, 6'h00, 7'h00, 7'h00, 1'b0}},
      '{8'h78, {8'h24, 8'h01, 8'h32, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h24, 5'h01, 6'h32, 6'h00, 7'h00, 7'h00, 1'b0}},
      '{8'h78, {8'h24, 8'h01, 8'h01, 8'h24, 8'h00, 8'h00}, 1'b1,
        {8'h24, 5'h01, 6'h01, 6'h24, 7'h00, 7'h00, 1'b0}},
      '{8'h78, {8'h24, 8'h01, 8'h01, 8'h00, 8'h60, 8'h99}, 1'b1,
        {8'h24, 5'h01, 6'h01, 6'h00, 7'h60, 7'h19, 1'b0}},
      '{8'h88, {8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h99, 5'h12, 6'h31, 6'h12, 7'h00, 7'h00, 1'b0}},
      '{8'h88, {8'h24, 8'h03, 8'h01, 8'h05, 8'h00, 8'h00}, 1'b0, UNTYPED},
      '{8'h05, {8'h23, 8'h02, 8'h28, 8'h23, 8'h30, 8'h00}, 1'b0, UNTYPED},
      '{8'h05, {8'h24, 8'h02, 8'h28, 8'h23, 8'h45, 8'h00}, 1'b0, UNTYPED},
      '{8'hFB, {8'h24, 8'h03, 8'h01, 8'h00, 8'h10, 8'h00}, 1'b0, UNTYPED},
      '{8'hFB, {8'h23, 8'h03, 8'h01, 8'h00, 8'h10, 8'h00}, 1'b0, UNTYPED},
      '{8'h7F, {8'h50, 8'h06, 8'h15, 8'h20, 8'h20, 8'h20}, 1'b0, UNTYPED},
      '{8'h80, {8'h50, 8'h06, 8'h15, 8'h08, 8'h40, 8'h40}, 1'b0, UNTYPED},
      '{8'h07, {8'h50, 8'h06, 8'h15, 8'h23, 8'h45, 8'h00}, 1'b0, UNTYPED},
      '{8'h73, {8'h50, 8'h11, 8'h30, 8'h13, 8'h30, 8'h00}, 1'b0, UNTYPED}
   };

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;

   rsp_type    local_times_due [$];
   logic [7:0] zone_setting = 8'h00;
   int         mismatches   = 0;
   bit         burst_mode   = 1'b0;
   bit         hold_armed   = 1'b0;

   bcd_date_time_zone_offset DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   function automatic logic [7:0] bcd_of(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic int value_of(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic bit digit_over(input logic [7:0] b);
      return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
   endfunction

   function automatic int days_in_month(input int mo, input int yr);
      case (mo)
         4, 6, 9, 11: return 30;
         2: return (yr % 4 == 0) ? 29 : 28;
         default: return 31;
      endcase
   endfunction

   function automatic rsp_type local_time_of(input req_type t, input logic [7:0] zone);
      rsp_type r;
      int      yr, mo, dy, hr, mi, off, mag;
      r.local_year_bcd   = t.year_bcd;
      r.local_month_bcd  = t.month_bcd[4:0];
      r.local_day_bcd    = t.day_bcd[5:0];
      r.local_hour_bcd   = t.hour_bcd[5:0];
      r.local_minute_bcd = t.minute_bcd[6:0];
      r.local_second_bcd = t.second_bcd[6:0];
      r.bad_digit = digit_over(t.year_bcd) || digit_over(t.month_bcd) ||
                    digit_over(t.day_bcd) || digit_over(t.hour_bcd) ||
                    digit_over(t.minute_bcd) || digit_over(t.second_bcd);
      if (r.bad_digit) return r;
      yr = value_of(t.year_bcd);
      mo = value_of(t.month_bcd);
      dy = value_of(t.day_bcd);
      hr = value_of(t.hour_bcd);
      mi = value_of(t.minute_bcd);
      // out of calendar range passes through with no offset applied
      if (mo < 1 || mo > 12 || dy < 1 || dy > 31 || hr > 23 || mi > 59) return r;
      off = $signed(zone);
      if (off > ZONE_LIMIT) off = ZONE_LIMIT;
      if (off < -ZONE_LIMIT) off = -ZONE_LIMIT;
      mag = (off < 0) ? -off : off;
      if (mag != 0) begin
         if (mag % 10 != 0) begin
            if (off > 0) begin
               if (mi >= 30) begin
                  mi -= 30;
                  hr += 1;
               end else begin
                  mi += 30;
               end
            end else begin
               if (mi < 30) begin
                  mi += 30;
                  hr -= 1;
               end else begin
                  mi -= 30;
               end
            end
         end
         hr += (off < 0) ? -(mag / 10) : mag / 10;
         if (hr < 0) begin
            hr += 24;
            dy -= 1;
            if (dy < 1) begin
               mo -= 1;
               if (mo < JANUARY) begin
                  mo = DECEMBER;
                  yr = (yr == 0) ? 99 : yr - 1;
               end
               dy = days_in_month(mo, yr);
            end
         end else if (hr > 23) begin
            hr -= 24;
            dy += 1;
            // december only rolls at 32, other months right past their length
            if (mo == DECEMBER) begin
               if (dy == 32) begin
                  dy = 1;
                  mo = JANUARY;
                  yr = (yr == 99) ? 0 : yr + 1;
               end
            end else if (dy == days_in_month(mo, yr) + 1) begin
               dy = 1;
               mo += 1;
            end
         end
      end
      r.local_year_bcd   = bcd_of(yr);
      r.local_month_bcd  = 5'(bcd_of(mo));
      r.local_day_bcd    = 6'(bcd_of(dy));
      r.local_hour_bcd   = 6'(bcd_of(hr));
      r.local_minute_bcd = 7'(bcd_of(mi));
      return r;
   endfunction

   function automatic int idle_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   // mostly well-formed timestamps pushed toward month, day and hour edges
   function automatic req_type random_stamp();
      req_type s;
      int      kind, yr, mo, dy, hr, len;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
         yr = $urandom_range(0, 1) ? 99 : 0;
      end else begin
         yr = $urandom_range(0, 99);
      end
      mo  = $urandom_range(1, 12);
      len = days_in_month(mo, yr);
      case ($urandom_range(0, 3))
         0: dy = 1;
         1: dy = $urandom_range(len - 1, 31);
         default: dy = $urandom_range(1, 31);
      endcase
      if ($urandom_range(0, 1)) begin
         hr = $urandom_range(0, 23);
      end else begin
         hr = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(22, 23);
      end
      s = {bcd_of(yr), bcd_of(mo), bcd_of(dy), bcd_of(hr), bcd_of($urandom_range(0, 59)),
           bcd_of($urandom_range(0, 99))};
      if (kind < 12) begin
         s = {16'($urandom), 32'($urandom)};
      end else if (kind < 20) begin
         case ($urandom_range(0, 3))
            0: s.month_bcd = bcd_of($urandom_range(0, 1) ? 0 : $urandom_range(13, 99));
            1: s.day_bcd = bcd_of($urandom_range(0, 1) ? 0 : $urandom_range(32, 99));
            2: s.hour_bcd = bcd_of($urandom_range(24, 99));
            default: s.minute_bcd = bcd_of($urandom_range(60, 99));
         endcase
      end
      return s;
   endfunction

   function automatic logic [7:0] phase_zone(input int phase);
      int v;
      case (phase)
         0: return 8'h78;
         1: return 8'h88;
         2: return 8'h00;
         default: begin
            if ($urandom_range(0, 4) == 0) return 8'($urandom);
            v = 5 * (int'($urandom_range(0, 48)) - 24);
            return v[7:0];
         end
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic offer(input req_type stamp, input rsp_type local_time);
      int gap;
      req_data  <= stamp;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      local_times_due.push_back(local_time);
      @(negedge clock);
      gap = (burst_mode || $urandom_range(0, 9) < 6) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // offset changes only once every item has drained
   task automatic write_zone(input logic [7:0] value);
      while (local_times_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      zone_setting = value;
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (local_times_due.size() == 0) begin
            $display("%0t: item %h arrived with nothing expected", $time, rsp_data);
            mismatches++;
         end else begin
            want = local_times_due.pop_front();
            compare_field("local_year_bcd", want.local_year_bcd, rsp_data.local_year_bcd);
            compare_field("local_month_bcd", 8'(want.local_month_bcd),
                          8'(rsp_data.local_month_bcd));
            compare_field("local_day_bcd", 8'(want.local_day_bcd),
                          8'(rsp_data.local_day_bcd));
            compare_field("local_hour_bcd", 8'(want.local_hour_bcd),
                          8'(rsp_data.local_hour_bcd));
            compare_field("local_minute_bcd", 8'(want.local_minute_bcd),
                          8'(rsp_data.local_minute_bcd));
            compare_field("local_second_bcd", 8'(want.local_second_bcd),
                          8'(rsp_data.local_second_bcd));
            compare_field("bad_digit", 8'(want.bad_digit), 8'(rsp_data.bad_digit));
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_armed) begin
            // long hold so the block fills and pushes back on the sender
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (burst_mode || $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (idle_len()) @(negedge clock);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("bcd_date_time_zone_offset regression: fail");
      $finish;
   end

   initial begin
      req_type stamp;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 8'h00;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].zone != zone_setting) begin
            req_valid <= 1'b0;
            write_zone(directed_rows[i].zone);
         end
         offer(directed_rows[i].stamp, directed_rows[i].typed ? directed_rows[i].local_time
                                       : local_time_of(directed_rows[i].stamp, zone_setting));
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         burst_mode = 1'b0;
         write_zone(phase_zone(phase));
         burst_mode = (phase % 4 == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 40) hold_armed = 1'b1;
            stamp = random_stamp();
            offer(stamp, local_time_of(stamp, zone_setting));
         end
      end
      req_valid <= 1'b0;
      burst_mode = 1'b0;

      while (local_times_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("bcd_date_time_zone_offset regression: pass");
      end else begin
         $display("bcd_date_time_zone_offset regression: fail");
      end
      $finish;
   end

endmodule
